### rtl/dpd_pkg.sv
package dpd_pkg;

   localparam int BODY_DEPTH = 64;
   localparam int ADDR_W     = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(BODY_DEPTH + 1);

   typedef logic [7:0]         byte_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;

   // framing characters
   localparam byte_type CH_DOLLAR = 8'h24;
   localparam byte_type CH_HASH   = 8'h23;
   localparam byte_type CH_ESCAPE = 8'h7d;
   localparam byte_type ESC_XOR   = 8'h20;
   localparam byte_type CH_ACK    = 8'h2b;
   localparam byte_type CH_NAK    = 8'h2d;
   localparam byte_type CH_BREAK  = 8'h03;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_CTRL  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // error codes
   localparam logic [1:0] ERR_BAD_PACKET = 2'd0;
   localparam logic [1:0] ERR_CHECKSUM   = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW   = 2'd2;

   // front-to-back command opcodes
   localparam logic [2:0] OP_CTRL     = 3'd0;
   localparam logic [2:0] OP_ERR      = 3'd1;
   localparam logic [2:0] OP_EMPTY    = 3'd2;
   localparam logic [2:0] OP_PKT      = 3'd3;
   localparam logic [2:0] OP_ERR_CTRL = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      byte_type   value;
      logic [1:0] err;
      count_type  count;
   } cmd_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      byte_type data;
   } wr_type;

   function automatic logic is_control(input byte_type c);
      return (c == CH_ACK) || (c == CH_NAK) || (c == CH_BREAK);
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_digit(input byte_type c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

### rtl/debug_packet_deframer_top.sv
// Packet deframer for a serial debug link: frames $body#hh packets.
// Input queue port: one received byte per beat on req_in_byte, taken when
// req_push is high and req_full is low. Result queue port: while rsp_empty
// is low the oldest result sits on rsp_kind/rsp_value/rsp_error_code/
// rsp_last; rsp_pop takes it.
// A parser front end classifies bytes, stores the body and checks the
// checksum and escapes; it hands commands through a two-entry queue to a
// back end that reads the body memory and drives the result register.
// A control byte or error goes through the command queue into the result
// register. A packet's bytes follow the second checksum digit: the back
// end reads each byte in BK_RD, an escaped one after a second read, and
// loads it from the registered read data in BK_DATA, holding on a stall.
// Bytes outside a body are taken one per cycle until the command queue
// fills; body bytes wait while the previous packet is still being read.
// Reset returns the parser to waiting for '$' and empties both queues.
// When the receiver stalls, the result register holds, the command queue
// fills and then req_full rises; nothing is lost.
module debug_packet_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last
);

   dpd_pkg::cmd_type push_cmd;
   dpd_pkg::cmd_type head_cmd;
   dpd_pkg::wr_type  body_wr;
   logic             cmd_push;
   logic             cmd_full;
   logic             cmd_pop;
   logic             cmd_empty;
   logic             pkt_done;

   dpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_full    (req_full),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd),
      .cmd_full    (cmd_full),
      .pkt_done    (pkt_done),
      .wr          (body_wr)
   );

   dpd_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (head_cmd)
   );

   dpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .wr             (body_wr),
      .cmd_empty      (cmd_empty),
      .cmd            (head_cmd),
      .cmd_pop        (cmd_pop),
      .pkt_done       (pkt_done),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

### rtl/dpd_cmd_queue.sv
module dpd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dpd_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output dpd_pkg::cmd_type pop_data
);

   dpd_pkg::cmd_type slot_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = slot_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wptr_in = wptr_ff + 1'(do_push);
      rptr_in = rptr_ff + 1'(do_pop);
      cnt_in  = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

### rtl/dpd_front.sv
module dpd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [7:0]       req_in_byte,
   output logic             req_full,
   output logic             cmd_push,
   output dpd_pkg::cmd_type cmd,
   input  logic             cmd_full,
   input  logic             pkt_done,
   output dpd_pkg::wr_type  wr
);

   localparam logic [1:0] MODE_WAIT = 2'd0;
   localparam logic [1:0] MODE_BODY = 2'd1;
   localparam logic [1:0] MODE_CS1  = 2'd2;
   localparam logic [1:0] MODE_CS2  = 2'd3;

   logic [1:0]         mode_ff, mode_in;
   dpd_pkg::count_type count_ff, count_in;
   dpd_pkg::byte_type  sum_ff, sum_in;
   dpd_pkg::byte_type  first_ff, first_in;
   logic               esc_pend_ff, esc_pend_in;
   logic               esc_bad_ff, esc_bad_in;
   logic               busy_ff, busy_in;

   logic               accept;
   logic [4:0]         hi, lo;
   dpd_pkg::byte_type  c;

   assign c        = req_in_byte;
   // body writes wait while the back end still reads the previous packet
   assign req_full = cmd_full || (mode_ff == MODE_BODY && busy_ff);
   assign accept   = req_push && !req_full;
   assign hi       = dpd_pkg::hex_digit(first_ff);
   assign lo       = dpd_pkg::hex_digit(c);

   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      first_in    = first_ff;
      esc_pend_in = esc_pend_ff;
      esc_bad_in  = esc_bad_ff;
      busy_in     = busy_ff && !pkt_done;
      cmd_push    = 1'b0;
      cmd         = '0;
      wr          = '0;

      if (accept) begin
         unique case (mode_ff)
            MODE_WAIT: begin
               if (c == dpd_pkg::CH_DOLLAR) begin
                  count_in    = '0;
                  sum_in      = '0;
                  esc_pend_in = 1'b0;
                  esc_bad_in  = 1'b0;
                  mode_in     = MODE_BODY;
               end else if (dpd_pkg::is_control(c)) begin
                  cmd_push  = 1'b1;
                  cmd.op    = dpd_pkg::OP_CTRL;
                  cmd.value = c;
               end
            end
            MODE_BODY: begin
               if (c == dpd_pkg::CH_HASH) begin
                  mode_in = MODE_CS1;
               end else if (c == dpd_pkg::CH_DOLLAR) begin
                  cmd_push    = 1'b1;
                  cmd.op      = dpd_pkg::OP_ERR;
                  cmd.err     = dpd_pkg::ERR_BAD_PACKET;
                  count_in    = '0;
                  sum_in      = '0;
                  esc_pend_in = 1'b0;
                  esc_bad_in  = 1'b0;
               end else if (count_ff >= dpd_pkg::COUNT_W'(dpd_pkg::BODY_DEPTH)) begin
                  cmd_push = 1'b1;
                  cmd.op   = dpd_pkg::OP_ERR;
                  cmd.err  = dpd_pkg::ERR_OVERFLOW;
                  count_in = '0;
                  sum_in   = '0;
                  mode_in  = MODE_WAIT;
               end else begin
                  wr.en    = 1'b1;
                  wr.addr  = count_ff[dpd_pkg::ADDR_W-1:0];
                  wr.data  = c;
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + c;
                  // track escape pairing so the back end only sees clean bodies
                  if (esc_pend_ff) begin
                     esc_pend_in = 1'b0;
                     if (c == dpd_pkg::CH_ESCAPE) begin
                        esc_bad_in = 1'b1;
                     end
                  end else if (c == dpd_pkg::CH_ESCAPE) begin
                     esc_pend_in = 1'b1;
                  end
               end
            end
            MODE_CS1, MODE_CS2: begin
               if (c == dpd_pkg::CH_DOLLAR) begin
                  cmd_push    = 1'b1;
                  cmd.op      = dpd_pkg::OP_ERR;
                  cmd.err     = dpd_pkg::ERR_BAD_PACKET;
                  count_in    = '0;
                  sum_in      = '0;
                  esc_pend_in = 1'b0;
                  esc_bad_in  = 1'b0;
                  mode_in     = MODE_BODY;
               end else if (dpd_pkg::is_control(c)) begin
                  cmd_push  = 1'b1;
                  cmd.op    = dpd_pkg::OP_ERR_CTRL;
                  cmd.value = c;
                  cmd.err   = dpd_pkg::ERR_BAD_PACKET;
                  count_in  = '0;
                  sum_in    = '0;
                  mode_in   = MODE_WAIT;
               end else if (mode_ff == MODE_CS1) begin
                  first_in = c;
                  mode_in  = MODE_CS2;
               end else begin
                  cmd_push = 1'b1;
                  priority if (!hi[4] || !lo[4]) begin
                     cmd.op  = dpd_pkg::OP_ERR;
                     cmd.err = dpd_pkg::ERR_BAD_PACKET;
                  end else if ({hi[3:0], lo[3:0]} != sum_ff) begin
                     cmd.op  = dpd_pkg::OP_ERR;
                     cmd.err = dpd_pkg::ERR_CHECKSUM;
                  end else if (esc_bad_ff || esc_pend_ff) begin
                     cmd.op  = dpd_pkg::OP_ERR;
                     cmd.err = dpd_pkg::ERR_BAD_PACKET;
                  end else if (count_ff == '0) begin
                     cmd.op = dpd_pkg::OP_EMPTY;
                  end else begin
                     cmd.op    = dpd_pkg::OP_PKT;
                     cmd.count = count_ff;
                     busy_in   = 1'b1;
                  end
                  count_in = '0;
                  sum_in   = '0;
                  mode_in  = MODE_WAIT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_WAIT;
         count_ff    <= '0;
         sum_ff      <= '0;
         first_ff    <= '0;
         esc_pend_ff <= 1'b0;
         esc_bad_ff  <= 1'b0;
         busy_ff     <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         first_ff    <= first_in;
         esc_pend_ff <= esc_pend_in;
         esc_bad_ff  <= esc_bad_in;
         busy_ff     <= busy_in;
      end
   end

endmodule

### rtl/dpd_back.sv
module dpd_back (
   input  logic             clock,
   input  logic             reset,
   input  dpd_pkg::wr_type  wr,
   input  logic             cmd_empty,
   input  dpd_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             pkt_done,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_value,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last
);

   localparam logic [1:0] BK_IDLE  = 2'd0;
   localparam logic [1:0] BK_RD    = 2'd1;
   localparam logic [1:0] BK_DATA  = 2'd2;
   localparam logic [1:0] BK_CTRL2 = 2'd3;

   dpd_pkg::byte_type  mem [dpd_pkg::BODY_DEPTH];
   dpd_pkg::byte_type  rdata_ff;
   logic               rd_en;
   dpd_pkg::addr_type  rd_addr;

   logic [1:0]         state_ff, state_in;
   dpd_pkg::count_type idx_ff, idx_in;
   dpd_pkg::count_type cnt_ff, cnt_in;
   logic               esc_ff, esc_in;
   dpd_pkg::byte_type  ctrl_ff, ctrl_in;

   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_kind_ff, out_kind_in;
   dpd_pkg::byte_type  out_value_ff, out_value_in;
   logic [1:0]         out_err_ff, out_err_in;
   logic               out_last_ff, out_last_in;

   logic               free, load;
   dpd_pkg::count_type idx_next;

   assign free           = !out_valid_ff || rsp_pop;
   assign idx_next       = idx_ff + 1'b1;
   assign rsp_empty      = !out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_error_code = out_err_ff;
   assign rsp_last       = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      esc_in       = esc_ff;
      ctrl_in      = ctrl_ff;
      cmd_pop      = 1'b0;
      pkt_done     = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[dpd_pkg::ADDR_W-1:0];
      load         = 1'b0;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && free) begin
               cmd_pop      = 1'b1;
               out_value_in = '0;
               out_err_in   = '0;
               out_last_in  = 1'b1;
               case (cmd.op)
                  dpd_pkg::OP_CTRL: begin
                     load         = 1'b1;
                     out_kind_in  = dpd_pkg::KIND_CTRL;
                     out_value_in = cmd.value;
                  end
                  dpd_pkg::OP_ERR: begin
                     load        = 1'b1;
                     out_kind_in = dpd_pkg::KIND_ERROR;
                     out_err_in  = cmd.err;
                  end
                  dpd_pkg::OP_EMPTY: begin
                     load        = 1'b1;
                     out_kind_in = dpd_pkg::KIND_EMPTY;
                  end
                  dpd_pkg::OP_ERR_CTRL: begin
                     load        = 1'b1;
                     out_kind_in = dpd_pkg::KIND_ERROR;
                     out_err_in  = cmd.err;
                     ctrl_in     = cmd.value;
                     state_in    = BK_CTRL2;
                  end
                  dpd_pkg::OP_PKT: begin
                     cnt_in   = cmd.count;
                     idx_in   = '0;
                     esc_in   = 1'b0;
                     state_in = BK_RD;
                  end
                  default: begin
                     // unused opcode: drop it
                  end
               endcase
            end
         end
         BK_RD: begin
            rd_en    = 1'b1;
            state_in = BK_DATA;
         end
         BK_DATA: begin
            if (rdata_ff == dpd_pkg::CH_ESCAPE && !esc_ff) begin
               esc_in   = 1'b1;
               idx_in   = idx_next;
               state_in = BK_RD;
            end else if (free) begin
               load         = 1'b1;
               out_kind_in  = dpd_pkg::KIND_BYTE;
               out_value_in = esc_ff ? (rdata_ff ^ dpd_pkg::ESC_XOR) : rdata_ff;
               out_err_in   = '0;
               out_last_in  = (idx_next == cnt_ff);
               esc_in       = 1'b0;
               idx_in       = idx_next;
               if (idx_next == cnt_ff) begin
                  pkt_done = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  state_in = BK_RD;
               end
            end
         end
         BK_CTRL2: begin
            if (free) begin
               load         = 1'b1;
               out_kind_in  = dpd_pkg::KIND_CTRL;
               out_value_in = ctrl_ff;
               out_err_in   = '0;
               out_last_in  = 1'b1;
               state_in     = BK_IDLE;
            end
         end
      endcase

      out_valid_in = load || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      esc_ff  <= esc_in;
      ctrl_ff <= ctrl_in;
      if (load) begin
         out_kind_ff  <= out_kind_in;
         out_value_ff <= out_value_in;
         out_err_ff   <= out_err_in;
         out_last_ff  <= out_last_in;
      end
   end

endmodule

### tb/sv/tb_debug_packet_deframer_top.sv
`timescale 1ns / 1ps

module tb_debug_packet_deframer_top;
   import dpd_pkg::*;

   typedef struct packed {
      logic [1:0] kind;
      byte_type   value;
      logic [1:0] err;
      logic       last;
   } dfr_result;

   typedef struct packed {
      byte_type  data;
      logic      typed;
      dfr_result res;
   } stim_row;

   typedef enum logic [1:0] {
      PM_HUNT,
      PM_BODY,
      PM_CSUM_HI,
      PM_CSUM_LO
   } parse_mode_e;

   localparam int FLAW_NONE    = 0;
   localparam int FLAW_SUM     = 1;
   localparam int FLAW_DIGIT   = 2;
   localparam int FLAW_CTRL    = 3;
   localparam int FLAW_STRAY   = 4;
   localparam int FLAW_ESC_END = 5;
   localparam int FLAW_ESC_ESC = 6;

   localparam int N_DIRECTED = 27;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_in_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_value;
   logic [1:0] rsp_error_code;
   logic       rsp_last;

   // predictor state
   parse_mode_e pmode;
   byte_type    body_mem [BODY_DEPTH];
   int          body_len;
   logic [7:0]  body_sum;
   byte_type    hi_digit;

   dfr_result   step_results [$];
   dfr_result   pending_results [$];

   int          fail_count;
   int          items_sent;
   logic        quiet;
   logic        hold_req;

   stim_row     dir_tab [N_DIRECTED];

   debug_packet_deframer_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("tb: failure");
      $finish;
   end

   function automatic logic is_ctl(input byte_type c);
      return c inside {CH_ACK, CH_NAK, CH_BREAK};
   endfunction

   function automatic int hex_nibble(input byte_type c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic void emit(input logic [1:0] kind, input byte_type value,
                                input logic [1:0] err, input logic last);
      dfr_result r;
      r.kind  = kind;
      r.value = value;
      r.err   = err;
      r.last  = last;
      step_results.insert(step_results.size(), r);
   endfunction

   // second checksum digit: verify, then unescape the stored body
   function automatic void close_packet(input byte_type lo_digit);
      int       hi;
      int       lo;
      int       i;
      byte_type b;
      hi = hex_nibble(hi_digit);
      lo = hex_nibble(lo_digit);
      if (hi < 0 || lo < 0) begin
         emit(KIND_ERROR, 8'h00, ERR_BAD_PACKET, 1'b1);
         return;
      end
      if (8'(hi * 16 + lo) != body_sum) begin
         emit(KIND_ERROR, 8'h00, ERR_CHECKSUM, 1'b1);
         return;
      end
      i = 0;
      while (i < body_len) begin
         b = body_mem[i];
         if (b == CH_ESCAPE) begin
            i++;
            if (i >= body_len || body_mem[i] == CH_ESCAPE) begin
               step_results.delete();
               emit(KIND_ERROR, 8'h00, ERR_BAD_PACKET, 1'b1);
               return;
            end
            b = body_mem[i] ^ ESC_XOR;
         end
         emit(KIND_BYTE, b, ERR_BAD_PACKET, 1'b0);
         i++;
      end
      if (step_results.size() == 0) begin
         emit(KIND_EMPTY, 8'h00, ERR_BAD_PACKET, 1'b1);
      end else begin
         step_results[step_results.size()-1].last = 1'b1;
      end
   endfunction

   function automatic void deframe_byte(input byte_type c);
      step_results.delete();
      case (pmode)
         PM_HUNT: begin
            if (c == CH_DOLLAR) begin
               body_len = 0;
               body_sum = 8'h00;
               pmode    = PM_BODY;
            end else if (is_ctl(c)) begin
               emit(KIND_CTRL, c, ERR_BAD_PACKET, 1'b1);
            end
         end
         PM_BODY: begin
            if (c == CH_HASH) begin
               pmode = PM_CSUM_HI;
            end else if (c == CH_DOLLAR) begin
               emit(KIND_ERROR, 8'h00, ERR_BAD_PACKET, 1'b1);
               body_len = 0;
               body_sum = 8'h00;
            end else if (body_len >= BODY_DEPTH) begin
               emit(KIND_ERROR, 8'h00, ERR_OVERFLOW, 1'b1);
               body_len = 0;
               body_sum = 8'h00;
               pmode    = PM_HUNT;
            end else begin
               body_mem[body_len] = c;
               body_len++;
               body_sum = body_sum + c;
            end
         end
         default: begin
            if (c == CH_DOLLAR) begin
               emit(KIND_ERROR, 8'h00, ERR_BAD_PACKET, 1'b1);
               pmode = PM_BODY;
            end else if (is_ctl(c)) begin
               emit(KIND_ERROR, 8'h00, ERR_BAD_PACKET, 1'b1);
               emit(KIND_CTRL, c, ERR_BAD_PACKET, 1'b1);
               pmode = PM_HUNT;
            end else if (pmode == PM_CSUM_HI) begin
               hi_digit = c;
               pmode    = PM_CSUM_LO;
            end else begin
               close_packet(c);
               pmode = PM_HUNT;
            end
            if (pmode != PM_CSUM_LO) begin
               body_len = 0;
               body_sum = 8'h00;
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // one beat on the input side; predicted (or typed) results are queued on acceptance
   task automatic send_byte(input byte_type b, input logic typed = 1'b0,
                            input dfr_result typed_res = '0);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 99) < 36) begin
            req_push = 1'b0;
         end else begin
            req_push    = 1'b1;
            req_in_byte = b;
         end
         @(posedge clock);
         if (req_push && !req_full) break;
      end
      items_sent++;
      deframe_byte(b);
      if (typed) begin
         pending_results.insert(pending_results.size(), typed_res);
      end else begin
         foreach (step_results[i]) begin
            pending_results.insert(pending_results.size(), step_results[i]);
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_push = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic byte_type ctl_char();
      case ($urandom_range(0, 2))
         0:       return CH_ACK;
         1:       return CH_NAK;
         default: return CH_BREAK;
      endcase
   endfunction

   function automatic byte_type hex_char(input logic [3:0] n);
      if (n < 10) return 8'("0") + 8'(n);
      return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
   endfunction

   function automatic byte_type plain_byte();
      byte_type x;
      do begin
         x = 8'($urandom_range(0, 255));
      end while (x inside {CH_DOLLAR, CH_HASH, CH_ESCAPE});
      return x;
   endfunction

   task automatic send_packet(input int len, input int flaw);
      byte_type   body [$];
      byte_type   pkt [$];
      byte_type   x;
      logic [7:0] csum;
      int         pos;
      body = {};
      while (body.size() < len) begin
         if (len - body.size() >= 2 && $urandom_range(0, 99) < 12) begin
            body.insert(body.size(), CH_ESCAPE);
            case ($urandom_range(0, 3))
               0:       body.insert(body.size(), CH_DOLLAR ^ ESC_XOR);
               1:       body.insert(body.size(), CH_HASH ^ ESC_XOR);
               2:       body.insert(body.size(), CH_ESCAPE ^ ESC_XOR);
               default: body.insert(body.size(), plain_byte());
            endcase
         end else begin
            body.insert(body.size(), plain_byte());
         end
      end
      pos = $urandom_range(0, body.size());
      case (flaw)
         FLAW_ESC_END: body.insert(body.size(), CH_ESCAPE);
         FLAW_ESC_ESC: begin
            body.insert(pos, CH_ESCAPE);
            body.insert(pos, CH_ESCAPE);
         end
         FLAW_STRAY:   body.insert(pos, CH_DOLLAR);
         default: ;
      endcase
      // a stray dollar restarts the body, so the sum covers only what follows it
      csum = 8'h00;
      foreach (body[i]) csum = (body[i] == CH_DOLLAR) ? 8'h00 : csum + body[i];
      if (flaw == FLAW_SUM) csum = csum + 8'($urandom_range(1, 255));
      pkt = {CH_DOLLAR};
      foreach (body[i]) pkt.insert(pkt.size(), body[i]);
      pkt.insert(pkt.size(), CH_HASH);
      pkt.insert(pkt.size(), hex_char(csum[7:4]));
      pkt.insert(pkt.size(), hex_char(csum[3:0]));
      pos = pkt.size() - 1 - $urandom_range(0, 1);
      if (flaw == FLAW_DIGIT) begin
         do begin
            x = 8'($urandom_range(0, 255));
         end while (hex_nibble(x) >= 0 || x == CH_DOLLAR || is_ctl(x));
         pkt[pos] = x;
      end else if (flaw == FLAW_CTRL) begin
         pkt[pos] = ctl_char();
      end
      foreach (pkt[i]) send_byte(pkt[i]);
   endtask

   // result side: random pops, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_pop   = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_pop = 1'b0;
            hold_left--;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 250;
            rsp_pop   = 1'b0;
         end else begin
            rsp_pop = quiet || ($urandom_range(0, 99) >= 36);
         end
      end
   end

   always @(posedge clock) begin : result_check
      dfr_result got;
      dfr_result want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.kind  = rsp_kind;
         got.value = rsp_value;
         got.err   = rsp_error_code;
         got.last  = rsp_last;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
         end else begin
            want = pending_results.pop_front();
            if (got.kind != want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.value != want.value)
               report_mismatch($sformatf("value %h, want %h", got.value, want.value));
            if (got.err != want.err)
               report_mismatch($sformatf("error_code %0d, want %0d", got.err, want.err));
            if (got.last != want.last)
               report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
         end
      end
   end

   initial begin
      int r;
      int len;
      int flaw;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_in_byte    = 8'h00;
      quiet          = 1'b0;
      hold_req       = 1'b0;
      fail_count     = 0;
      items_sent     = 0;
      pmode          = PM_HUNT;
      body_len       = 0;
      body_sum       = 8'h00;
      hi_digit       = 8'h00;
      foreach (body_mem[i]) body_mem[i] = 8'h00;

      dir_tab = '{
         '{CH_ACK,    1'b1, '{KIND_CTRL,  CH_ACK,   ERR_BAD_PACKET, 1'b1}},
         '{CH_NAK,    1'b1, '{KIND_CTRL,  CH_NAK,   ERR_BAD_PACKET, 1'b1}},
         '{CH_BREAK,  1'b1, '{KIND_CTRL,  CH_BREAK, ERR_BAD_PACKET, 1'b1}},
         '{8'hff,     1'b0, '0},
         '{8'h00,     1'b0, '0},
         // stray dollar, then an empty packet
         '{CH_DOLLAR, 1'b0, '0},
         '{CH_DOLLAR, 1'b1, '{KIND_ERROR, 8'h00,    ERR_BAD_PACKET, 1'b1}},
         '{CH_HASH,   1'b0, '0},
         '{8'h30,     1'b0, '0},
         '{8'h30,     1'b1, '{KIND_EMPTY, 8'h00,    ERR_BAD_PACKET, 1'b1}},
         // escape as the last body byte
         '{CH_DOLLAR, 1'b0, '0},
         '{CH_ESCAPE, 1'b0, '0},
         '{CH_HASH,   1'b0, '0},
         '{8'h37,     1'b0, '0},
         '{8'h44,     1'b1, '{KIND_ERROR, 8'h00,    ERR_BAD_PACKET, 1'b1}},
         // checksum mismatch
         '{CH_DOLLAR, 1'b0, '0},
         '{8'h00,     1'b0, '0},
         '{CH_HASH,   1'b0, '0},
         '{8'h30,     1'b0, '0},
         '{8'h31,     1'b1, '{KIND_ERROR, 8'h00,    ERR_CHECKSUM,   1'b1}},
         // non-hex first digit
         '{CH_DOLLAR, 1'b0, '0},
         '{CH_HASH,   1'b0, '0},
         '{8'h67,     1'b0, '0},
         '{8'h30,     1'b1, '{KIND_ERROR, 8'h00,    ERR_BAD_PACKET, 1'b1}},
         // control byte in the checksum
         '{CH_DOLLAR, 1'b0, '0},
         '{CH_HASH,   1'b0, '0},
         '{CH_NAK,    1'b0, '0}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) send_byte(dir_tab[i].data, dir_tab[i].typed, dir_tab[i].res);
      drain();

      // full-depth body while the result side is held off; the next body stalls behind it
      hold_req = 1'b1;
      send_packet(BODY_DEPTH, FLAW_NONE);
      send_packet(4, FLAW_ESC_ESC);

      // overflow with no idling on either side
      quiet = 1'b1;
      send_packet(BODY_DEPTH + 1, FLAW_NONE);
      quiet = 1'b0;

      while (items_sent < 210) begin
         if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 3)) begin
               send_byte(($urandom_range(0, 2) == 0) ? ctl_char()
                                                     : 8'($urandom_range(0, 255)));
            end
         end
         r = $urandom_range(0, 99);
         if (r < 85)      len = $urandom_range(0, 8);
         else if (r < 95) len = $urandom_range(9, 24);
         else             len = $urandom_range(BODY_DEPTH - 4, BODY_DEPTH + 2);
         r = $urandom_range(0, 99);
         if (r < 72)      flaw = FLAW_NONE;
         else if (r < 78) flaw = FLAW_SUM;
         else if (r < 83) flaw = FLAW_DIGIT;
         else if (r < 87) flaw = FLAW_CTRL;
         else if (r < 91) flaw = FLAW_STRAY;
         else if (r < 95) flaw = FLAW_ESC_END;
         else             flaw = FLAW_ESC_ESC;
         send_packet(len, flaw);
      end

      drain();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/dpd_pkg.sv
rtl/dpd_cmd_queue.sv
rtl/dpd_front.sv
rtl/dpd_back.sv
rtl/debug_packet_deframer_top.sv
tb/sv/tb_debug_packet_deframer_top.sv
